[hdl/rrq_pkg.sv]
// Shared types and constants for the retransmit queue.
package rrq_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ATTEMPTS = 2'd1;

  typedef enum logic [1:0] {
    OP_ENQUEUE  = 2'd0,
    OP_RESPONSE = 2'd1,
    OP_TICK     = 2'd2,
    OP_CLEAR    = 2'd3
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [31:0] now_ms;
    logic [7:0]  item_type;
    logic [15:0] item_sequence;
    logic        link_up;
    logic        tx_accepts;
  } in_item_t;

  typedef struct packed {
    logic        send_valid;
    logic [2:0]  send_slot;
    logic [7:0]  send_type;
    logic [15:0] send_sequence;
    logic        send_is_retry;
    logic        enqueue_accepted;
    logic        response_matched;
    logic        dropped;
    logic [3:0]  queue_count;
    logic [31:0] retry_total;
    logic [31:0] drop_total;
    logic [31:0] overflow_total;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  frame_type;
    logic [15:0] frame_seq;
  } entry_t;

endpackage

[hdl/rrq_in_if.sv]
// Input channel: one operation beat per handshake.
interface rrq_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [31:0] now_ms;
  logic [7:0]  item_type;
  logic [15:0] item_sequence;
  logic        link_up;
  logic        tx_accepts;

  modport source (output valid, op, now_ms, item_type, item_sequence, link_up, tx_accepts,
                  input ready);
  modport sink   (input valid, op, now_ms, item_type, item_sequence, link_up, tx_accepts,
                  output ready);
endinterface

[hdl/rrq_out_if.sv]
// Result channel: one result beat per operation.
interface rrq_out_if;
  logic        valid;
  logic        ready;
  logic        send_valid;
  logic [2:0]  send_slot;
  logic [7:0]  send_type;
  logic [15:0] send_sequence;
  logic        send_is_retry;
  logic        enqueue_accepted;
  logic        response_matched;
  logic        dropped;
  logic [3:0]  queue_count;
  logic [31:0] retry_total;
  logic [31:0] drop_total;
  logic [31:0] overflow_total;

  modport source (output valid, send_valid, send_slot, send_type, send_sequence,
                  send_is_retry, enqueue_accepted, response_matched, dropped,
                  queue_count, retry_total, drop_total, overflow_total,
                  input ready);
  modport sink   (input valid, send_valid, send_slot, send_type, send_sequence,
                  send_is_retry, enqueue_accepted, response_matched, dropped,
                  queue_count, retry_total, drop_total, overflow_total,
                  output ready);
endinterface

[hdl/rrq_cfg_if.sv]
// Configuration write channel: register index and data per beat.
interface rrq_cfg_if import rrq_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[hdl/reliable_retransmit_queue.sv]
// Top level of the retransmit queue: channels, beat registers and configuration.
//
// in_ch carries one operation per beat (enqueue, acknowledgement, tick, clear)
// with the current time and link state; out_ch returns exactly one result beat
// per operation, in order. cfg_ch writes the timeout and attempt limit and is
// always ready; write it only while no operation is in flight.
// Frame bodies are held outside; send_slot names the slot to transmit.
// A beat taken into the input register is processed once the result register can
// advance, and its result is then held in the result register until out_ch takes it.
// Throughput: one beat per cycle while out_ch does not stall; the head service
// between the input register and the result register is combinational, and the
// frame store's two registered read ports are pointed at the next head ahead of time.
// Reset clears the queue (head slot 0, empty), all counters, and sets
// the timeout to 100 ms and the attempt limit to 5; store contents are left.
// When out_ch stalls, the result register holds and the input register fills;
// in_ch.ready drops only once both are occupied.
module reliable_retransmit_queue import rrq_pkg::*; #(
  parameter int QUEUE_DEPTH = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  rrq_in_if.sink     in_ch,
  rrq_out_if.source  out_ch,
  rrq_cfg_if.sink    cfg_ch
);

  localparam int SW = $clog2(QUEUE_DEPTH);

  logic        s1_valid_r;
  in_item_t    s1_item_r;
  logic        out_valid_r;
  out_item_t   out_item_r;
  logic [15:0] timeout_r;
  logic [3:0]  max_att_r;
  logic        advance;
  logic        go;

  logic          we;
  logic [SW-1:0] waddr;
  entry_t        wdata;
  logic [SW-1:0] raddr_a;
  logic [SW-1:0] raddr_b;
  entry_t        rdata_a;
  entry_t        rdata_b;
  out_item_t     result;

  assign advance      = !out_valid_r || out_ch.ready;
  assign go           = s1_valid_r && advance;
  assign in_ch.ready  = !s1_valid_r || advance;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_item_r.op            <= op_t'(in_ch.op);
      s1_item_r.now_ms        <= in_ch.now_ms;
      s1_item_r.item_type     <= in_ch.item_type;
      s1_item_r.item_sequence <= in_ch.item_sequence;
      s1_item_r.link_up       <= in_ch.link_up;
      s1_item_r.tx_accepts    <= in_ch.tx_accepts;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      out_item_r <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= 16'd100;
      max_att_r <= 4'd5;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_TIMEOUT:      timeout_r <= cfg_ch.data;
        REG_MAX_ATTEMPTS: max_att_r <= cfg_ch.data[3:0];
        default: begin
        end
      endcase
    end
  end

  rrq_ctrl #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .go      (go),
    .item    (s1_item_r),
    .timeout (timeout_r),
    .max_att (max_att_r),
    .rd_head (rdata_a),
    .rd_next (rdata_b),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .result  (result)
  );

  rrq_store #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_store (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  assign out_ch.valid            = out_valid_r;
  assign out_ch.send_valid       = out_item_r.send_valid;
  assign out_ch.send_slot        = out_item_r.send_slot;
  assign out_ch.send_type        = out_item_r.send_type;
  assign out_ch.send_sequence    = out_item_r.send_sequence;
  assign out_ch.send_is_retry    = out_item_r.send_is_retry;
  assign out_ch.enqueue_accepted = out_item_r.enqueue_accepted;
  assign out_ch.response_matched = out_item_r.response_matched;
  assign out_ch.dropped          = out_item_r.dropped;
  assign out_ch.queue_count      = out_item_r.queue_count;
  assign out_ch.retry_total      = out_item_r.retry_total;
  assign out_ch.drop_total       = out_item_r.drop_total;
  assign out_ch.overflow_total   = out_item_r.overflow_total;

  a_go_needs_beat: assert property (@(posedge clk) disable iff (!rst_n)
    go |=> out_valid_r)
    else $error("processed beat did not reach the result register");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |=> (out_valid_r && $stable(out_item_r)))
    else $error("result beat changed while stalled");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !advance) |-> !in_ch.ready)
    else $error("input register overrun");

endmodule

[hdl/rrq_store.sv]
// Frame type/sequence store: one write port, two registered read ports with bypass.
module rrq_store import rrq_pkg::*; #(
  parameter int QUEUE_DEPTH = 8,
  localparam int SW = $clog2(QUEUE_DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [SW-1:0] waddr,
  input  entry_t        wdata,
  input  logic [SW-1:0] raddr_a,
  input  logic [SW-1:0] raddr_b,
  output entry_t        rdata_a,
  output entry_t        rdata_b
);

  entry_t mem [QUEUE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_a <= (we && waddr == raddr_a) ? wdata : mem[raddr_a];
    rdata_b <= (we && waddr == raddr_b) ? wdata : mem[raddr_b];
  end

endmodule

[hdl/rrq_ctrl.sv]
// Queue state, head service and counters: one operation per cycle in which go is high.
module rrq_ctrl import rrq_pkg::*; #(
  parameter int QUEUE_DEPTH = 8,
  localparam int SW = $clog2(QUEUE_DEPTH),
  localparam int CW = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          go,
  input  in_item_t      item,
  input  logic [15:0]   timeout,
  input  logic [3:0]    max_att,
  input  entry_t        rd_head,
  input  entry_t        rd_next,
  output logic          we,
  output logic [SW-1:0] waddr,
  output entry_t        wdata,
  output logic [SW-1:0] raddr_a,
  output logic [SW-1:0] raddr_b,
  output out_item_t     result
);

  logic [SW-1:0] head_r, head_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [3:0]    att_r, att_nxt;
  logic [31:0]   last_r, last_nxt;
  logic [31:0]   retry_r, retry_nxt;
  logic [31:0]   drop_r, drop_nxt;
  logic [31:0]   ovf_r, ovf_nxt;

  logic [SW:0]   tail_sum;
  logic [3:0]    limit;
  logic [31:0]   elapsed;
  logic          srv_en;
  logic          snd_valid;
  logic          snd_retry;
  logic          accepted;
  logic          matched;
  logic          dropped;
  logic [SW-1:0] snd_slot;
  entry_t        new_e, cur_e, nxt_e, snd_e;

  function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] s);
    return (s == SW'(QUEUE_DEPTH - 1)) ? '0 : s + SW'(1);
  endfunction

  assign new_e    = '{frame_type: item.item_type, frame_seq: item.item_sequence};
  assign tail_sum = (SW+1)'(head_r) + (SW+1)'(count_r);
  assign waddr    = (tail_sum >= (SW+1)'(QUEUE_DEPTH)) ?
                    SW'(tail_sum - (SW+1)'(QUEUE_DEPTH)) : SW'(tail_sum);
  assign wdata    = new_e;
  assign limit    = (max_att == 4'd0) ? 4'd1 : max_att;

  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    att_nxt   = att_r;
    last_nxt  = last_r;
    retry_nxt = retry_r;
    drop_nxt  = drop_r;
    ovf_nxt   = ovf_r;
    we        = 1'b0;
    accepted  = 1'b0;
    matched   = 1'b0;
    dropped   = 1'b0;
    srv_en    = 1'b0;
    snd_valid = 1'b0;
    snd_retry = 1'b0;
    snd_slot  = '0;
    snd_e     = '0;
    cur_e     = rd_head;
    nxt_e     = rd_next;
    elapsed   = '0;
    if (go) begin
      case (item.op)
        OP_ENQUEUE: begin
          if (count_r == CW'(QUEUE_DEPTH)) begin
            ovf_nxt = ovf_r + 32'd1;
          end else begin
            we        = 1'b1;
            accepted  = 1'b1;
            count_nxt = count_r + CW'(1);
            srv_en    = 1'b1;
            if (count_r == CW'(0)) begin
              cur_e    = new_e;
              att_nxt  = 4'd0;
              last_nxt = item.now_ms;
            end
            if (count_r == CW'(1)) begin
              nxt_e = new_e;
            end
          end
        end
        OP_RESPONSE: begin
          if (count_r != CW'(0) && rd_head == new_e) begin
            matched   = 1'b1;
            head_nxt  = slot_inc(head_r);
            count_nxt = count_r - CW'(1);
            cur_e     = rd_next;
            att_nxt   = 4'd0;
            srv_en    = 1'b1;
          end
        end
        OP_TICK: begin
          srv_en = 1'b1;
        end
        OP_CLEAR: begin
          head_nxt  = '0;
          count_nxt = '0;
        end
        default: begin
        end
      endcase

      // head service; a drop hands straight over to the next, never-sent entry
      if (srv_en && item.link_up && count_nxt != CW'(0)) begin
        elapsed = item.now_ms - last_nxt;
        if (att_nxt == 4'd0 || elapsed >= {16'd0, timeout}) begin
          if (att_nxt >= limit) begin
            drop_nxt  = drop_r + 32'd1;
            dropped   = 1'b1;
            head_nxt  = slot_inc(head_nxt);
            count_nxt = count_nxt - CW'(1);
            att_nxt   = 4'd0;
            cur_e     = nxt_e;
          end
          if (count_nxt != CW'(0) && item.tx_accepts) begin
            snd_valid = 1'b1;
            snd_retry = (att_nxt != 4'd0);
            if (snd_retry) begin
              retry_nxt = retry_r + 32'd1;
            end
            att_nxt  = att_nxt + 4'd1;
            last_nxt = item.now_ms;
            snd_slot = head_nxt;
            snd_e    = cur_e;
          end
        end
      end
    end
  end

  assign raddr_a = head_nxt;
  assign raddr_b = slot_inc(head_nxt);

  always_comb begin
    result.send_valid       = snd_valid;
    result.send_slot        = 3'(snd_slot);
    result.send_type        = snd_e.frame_type;
    result.send_sequence    = snd_e.frame_seq;
    result.send_is_retry    = snd_retry;
    result.enqueue_accepted = accepted;
    result.response_matched = matched;
    result.dropped          = dropped;
    result.queue_count      = 4'(count_nxt);
    result.retry_total      = retry_nxt;
    result.drop_total       = drop_nxt;
    result.overflow_total   = ovf_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
      att_r   <= '0;
      retry_r <= '0;
      drop_r  <= '0;
      ovf_r   <= '0;
    end else begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
      att_r   <= att_nxt;
      retry_r <= retry_nxt;
      drop_r  <= drop_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    last_r <= last_nxt;
  end

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_head_range: assert property (@(posedge clk) disable iff (!rst_n)
    head_r <= SW'(QUEUE_DEPTH - 1))
    else $error("head slot beyond depth");

  a_send_gated: assert property (@(posedge clk) disable iff (!rst_n)
    (go && snd_valid) |-> (item.link_up && item.tx_accepts && count_nxt != CW'(0)))
    else $error("send without link, transmitter room or entry");

  a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !go |=> ($stable(count_r) && $stable(head_r) && $stable(retry_r) && $stable(drop_r)))
    else $error("queue state moved without a beat");

endmodule
